// ===== design/bsss_pkg.sv =====
// Shared types and codes for the bounded stack with search and sort.
`default_nettype none
package bsss_pkg;

  // Action codes carried on in_action
  localparam logic [2:0] ACT_PUSH = 3'd0;
  localparam logic [2:0] ACT_POP  = 3'd1;
  localparam logic [2:0] ACT_PEEK = 3'd2;
  localparam logic [2:0] ACT_FIND = 3'd3;
  localparam logic [2:0] ACT_SORT = 3'd4;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 7;

  // Per-cycle operation applied to every cell of the chain
  typedef enum logic [2:0] {
    C_HOLD,
    C_PUSH,        // shift toward the bottom, top cell takes the pushed value
    C_POP,         // shift toward the top
    C_SWAP,        // one odd-even transposition phase
    C_FIND_LOAD,   // latch the compare result into the hit flag
    C_FIND_SHIFT   // move hit flags one cell toward the top
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;  // parity of the upper cell in each compare pair
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/bsss_cell.sv =====
// One stack slot: value, valid flag and find hit flag, linked to both neighbors.
`default_nettype none
module bsss_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bsss_pkg::cell_ctl_t       ctl,
  input  wire logic                      pair_down,   // partner in this phase is the cell below
  input  wire logic signed [31:0]        key,
  input  wire logic signed [31:0]        above_value,
  input  wire logic                      above_valid,
  input  wire logic signed [31:0]        below_value,
  input  wire logic                      below_valid,
  input  wire logic                      below_hit,
  output logic signed [31:0]             value,
  output logic                           valid,
  output logic                           hit
);
  import bsss_pkg::*;

  logic signed [31:0] value_r, value_nxt;
  logic               valid_r, valid_nxt;
  logic               hit_r, hit_nxt;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    case (ctl.op)
      C_PUSH: begin
        value_nxt = above_value;
        valid_nxt = above_valid;
      end
      C_POP: begin
        value_nxt = below_value;
        valid_nxt = below_valid;
      end
      C_SWAP: begin
        if (pair_down) begin
          // upper of the pair keeps the smaller value
          if (valid_r && below_valid && (below_value < value_r)) value_nxt = below_value;
        end else begin
          // lower of the pair keeps the larger value
          if (valid_r && above_valid && (above_value > value_r)) value_nxt = above_value;
        end
      end
      C_FIND_LOAD:  hit_nxt = valid_r && (value_r == key);
      C_FIND_SHIFT: hit_nxt = below_hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    hit_r   <= hit_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;
  assign hit   = hit_r;

endmodule
`default_nettype wire

// ===== design/bounded_stack_search_sort.sv =====
// Top level: bounded LIFO stack built as a chain of cells, with find and sort.
`default_nettype none
// A bounded LIFO stack of signed 32-bit values held in a row of DEPTH cells,
// top of stack in cell 0. A command is taken at a clock edge with start high
// and busy low; its single result shows on the out_ ports for exactly one
// cycle, flagged by out_strobe, and the receiver cannot stall it. Push, pop,
// peek and the unused action codes need no busy state: the result appears
// the cycle after the transfer and busy stays low, so these can be issued
// every cycle. Find latches a compare in every cell, then shifts the hit
// flags toward the top one cell per cycle and counts, until a hit reaches
// cell 0 or the scan passes the last valid entry with no match.
// Sort runs odd-even transposition phases across the chain, one phase per
// cycle, count phases in all (an empty or one-entry stack answers without
// going busy, like a push). busy is high while a find or sort
// is in flight. capacity_limit (cfg_wdata, reset 64) is written whenever
// cfg_we is high and should change only while the stack is idle; values
// above DEPTH act as DEPTH, zero refuses every push. Lowering it below the
// count drops nothing. No clearing pass is needed after reset.
module bounded_stack_search_sort #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_wdata,
  output logic                    out_strobe,
  output logic                    out_success,
  output logic signed [31:0]      out_value,
  output logic [6:0]              out_found_position,
  output logic [6:0]              out_entry_count,
  output logic                    out_is_empty,
  output logic                    out_is_full
);
  import bsss_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);        // count width, holds DEPTH
  localparam int CMPW = (CW > POS_W) ? CW : POS_W; // width for capacity compares

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SORT} state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  step_r;       // scan position or sort phase
  logic [6:0]     cap_r;

  cell_ctl_t          ctl;
  logic signed [31:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_valid;
  logic [DEPTH-1:0]   cell_hit;

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] up_v, dn_v;
    logic               up_ok, dn_ok, dn_hit, pdown;

    if (i == 0) begin : g_top
      assign up_v  = in_item_value;   // pushed value enters at the top
      assign up_ok = (ctl.op == C_PUSH);
    end else begin : g_mid
      assign up_v  = cell_value[i-1];
      assign up_ok = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign dn_v   = cell_value[i];
      assign dn_ok  = 1'b0;
      assign dn_hit = 1'b0;
    end else begin : g_nbot
      assign dn_v   = cell_value[i+1];
      assign dn_ok  = cell_valid[i+1];
      assign dn_hit = cell_hit[i+1];
    end

    assign pdown = (ctl.phase == 1'(i % 2));

    bsss_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .pair_down   (pdown),
      .key         (in_item_value),
      .above_value (up_v),
      .above_valid (up_ok),
      .below_value (dn_v),
      .below_valid (dn_ok),
      .below_hit   (dn_hit),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .hit         (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------------
  // Capacity and command decode
  // ---------------------------------------------------------------------
  logic [CMPW-1:0] eff_cap;
  logic            accept;
  logic            push_ok, not_empty;
  logic            scan_end, sort_end;

  assign eff_cap   = (CMPW'(cap_r) < CMPW'(DEPTH)) ? CMPW'(cap_r) : CMPW'(DEPTH);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign push_ok   = CMPW'(count_r) < eff_cap;
  assign not_empty = (count_r != '0);
  assign scan_end  = (step_r == count_r);
  assign sort_end  = (step_r == CW'(count_r - 1'b1));

  // Per-cycle operation broadcast to the chain
  always_comb begin
    ctl.op    = C_HOLD;
    ctl.phase = step_r[0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PUSH: if (push_ok) ctl.op = C_PUSH;
            ACT_POP:  if (not_empty) ctl.op = C_POP;
            ACT_FIND: ctl.op = C_FIND_LOAD;
            default:  ctl.op = C_HOLD;
          endcase
        end
      end
      ST_SCAN: if (!scan_end && !cell_hit[0]) ctl.op = C_FIND_SHIFT;
      ST_SORT: ctl.op = C_SWAP;
      default: ctl.op = C_HOLD;
    endcase
  end

  // Result of a command that finishes in the cycle it is taken
  logic               imm_emit, imm_success;
  logic signed [31:0] imm_value;
  logic [CW-1:0]      imm_count;

  always_comb begin
    imm_emit    = 1'b1;
    imm_success = 1'b0;
    imm_value   = '0;
    imm_count   = count_r;
    case (in_action)
      ACT_PUSH: if (push_ok) begin
        imm_success = 1'b1;
        imm_count   = CW'(count_r + 1'b1);
      end
      ACT_POP: if (not_empty) begin
        imm_success = 1'b1;
        imm_value   = cell_value[0];
        imm_count   = CW'(count_r - 1'b1);
      end
      ACT_PEEK: if (not_empty) begin
        imm_success = 1'b1;
        imm_value   = cell_value[0];
      end
      ACT_FIND: imm_emit = 1'b0;
      ACT_SORT: begin
        imm_emit    = (count_r <= CW'(1));
        imm_success = 1'b1;
      end
      default: ;
    endcase
  end

  // Status reported with whatever result goes out this cycle
  logic [CW-1:0] st_count;
  logic [CW-1:0] hit_pos;

  assign st_count = (state_r == ST_IDLE) ? imm_count : count_r;
  assign hit_pos  = CW'(step_r + 1'b1);

  // ---------------------------------------------------------------------
  // Control state and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      step_r     <= '0;
      cap_r      <= 7'd64;
      out_strobe <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      out_strobe         <= 1'b0;
      out_entry_count    <= POS_W'(CMPW'(st_count));
      out_is_empty       <= (st_count == '0);
      out_is_full        <= (CMPW'(st_count) >= eff_cap);
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            count_r            <= imm_count;
            step_r             <= '0;
            out_strobe         <= imm_emit;
            out_success        <= imm_success;
            out_value          <= imm_value;
            out_found_position <= '0;
            if (in_action == ACT_FIND) begin
              state_r <= ST_SCAN;
            end else if ((in_action == ACT_SORT) && !imm_emit) begin
              state_r <= ST_SORT;
            end
          end
        end
        ST_SCAN: begin
          // hit flags move up one cell per cycle; cell 0 sees them in order
          if (scan_end) begin
            state_r            <= ST_IDLE;
            out_strobe         <= 1'b1;
            out_success        <= 1'b0;
            out_value          <= '0;
            out_found_position <= '0;
          end else if (cell_hit[0]) begin
            state_r            <= ST_IDLE;
            out_strobe         <= 1'b1;
            out_success        <= 1'b1;
            out_value          <= '0;
            out_found_position <= POS_W'(CMPW'(hit_pos));
          end else begin
            step_r <= CW'(step_r + 1'b1);
          end
        end
        ST_SORT: begin
          // count phases of odd-even transposition leave the chain sorted
          if (sort_end) begin
            state_r            <= ST_IDLE;
            out_strobe         <= 1'b1;
            out_success        <= 1'b1;
            out_value          <= '0;
            out_found_position <= '0;
          end else begin
            step_r <= CW'(step_r + 1'b1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Valid flags in the chain always agree with the entry counter
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell valid flags disagree with count");

  // Valid flags form a solid run from the top
  a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("valid flags not contiguous from top");

  // A find or sort in flight leaves count unchanged
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> $stable(count_r))
    else $error("count changed during find or sort");

  // A taken command that completes at once reports in the next cycle
  a_imm_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action != ACT_FIND) && (in_action != ACT_SORT) |=> out_strobe)
    else $error("missing result for single-cycle command");

endmodule
`default_nettype wire
